// ===== rtl/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg
// Shared widths, codes, command/status structs and helpers for the grid slot
// allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsa_pkg;

  // Field widths
  localparam int KIND_W     = 1;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 11;
  localparam int LAYER_W    = 11;
  localparam int CELLS_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Bitmap row organisation
  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = 5;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LAYERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW        = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // take the input transfer
    logic mul;       // register capacity products
    logic decide;    // full / growth / range decision, first row read
    logic modify;    // write back the target row, scan it
    logic scan;      // scan a further row
    logic load_out;  // load the result register
    logic clr_wr;    // clearing pass write
  } gsa_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fresh;      // grid reconfiguration write
    logic fail;       // item ends without touching the bitmap
    logic scan_more;  // forward scan needs another row
    logic clr_last;   // clearing pass on its last row
  } gsa_stat_t;

  // Index of the lowest set bit (0 when none)
  function automatic logic [WORD_SH-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WORD_SH-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_SH'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gsa_channels.sv =====
// ----------------------------------------------------------------------------
// gsa_channels
// Valid/ready channel interfaces: request channel and result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gsa_in_if;
  import gsa_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink   (input valid, input kind, input slot, output ready);
endinterface

interface gsa_out_if;
  import gsa_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_out;
  logic [STATUS_W-1:0] status;
  logic                grew;
  logic [CAP_W-1:0]    capacity;

  modport source (output valid, output slot_out, output status, output grew,
                  output capacity, input ready);
  modport sink   (input valid, input slot_out, input status, input grew,
                  input capacity, output ready);
endinterface

`default_nettype wire

// ===== rtl/gsa_ram.sv =====
// ----------------------------------------------------------------------------
// gsa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/gsa_datapath.sv =====
// ----------------------------------------------------------------------------
// gsa_datapath
// Configuration, layer count, free pointer, capacity arithmetic, used-bit
// bitmap (rows of 32 slots in RAM) with row scan, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsa_datapath #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [gsa_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [gsa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [gsa_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [gsa_pkg::SLOT_W-1:0]        in_slot,
  input  wire gsa_pkg::gsa_cmd_t                 cmd,
  output gsa_pkg::gsa_stat_t                     st,
  output logic      [gsa_pkg::SLOT_W-1:0]        out_slot_out,
  output logic      [gsa_pkg::STATUS_W-1:0]      out_status,
  output logic                                   out_grew,
  output logic      [gsa_pkg::CAP_W-1:0]         out_capacity
);
  import gsa_pkg::*;

  localparam int SW    = $clog2(MAX_SLOTS + 1);
  localparam int NROWS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int RW    = NROWS > 1 ? $clog2(NROWS) : 1;
  localparam int GW    = RW + WORD_SH;
  localparam int CW0   = (GW + 1) > SW ? (GW + 1) : SW;
  localparam int CW    = CW0 > SLOT_W ? CW0 : SLOT_W;
  localparam int NLW   = LAYER_W + 1;
  localparam int PW    = NLW + CELLS_W;
  localparam int LMAX  = (2 ** LAYER_W) - 1;

  // configuration and grid state
  logic [LAYER_W-1:0]  init_layers_r;
  logic [CELLS_W-1:0]  cells_r;
  logic                grow_en_r;
  logic [LAYER_W-1:0]  layer_r;
  logic [SW-1:0]       next_free_r;
  logic [RW-1:0]       clr_row_r;

  // per-item working registers
  logic [KIND_W-1:0]   kind_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [PW-1:0]       prod_r;
  logic [PW-1:0]       gprod_r;
  logic [NLW-1:0]      nl_r;
  logic [SW-1:0]       cap_r;
  logic [SW-1:0]       pos_r;
  logic [RW-1:0]       row_r;
  logic [STATUS_W-1:0] status_r;
  logic                grew_r;

  logic [NLW-1:0]       nl_c;
  logic [SW-1:0]        cap_now;
  logic                 cap_full;
  logic                 grow_ok;
  logic                 rel_oor;
  logic [WORD_BITS-1:0] rd_data;
  logic [WORD_BITS-1:0] bit_sel;
  logic [WORD_BITS-1:0] mod_word;
  logic [WORD_BITS-1:0] scan_word;
  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_SH-1:0]   enc;
  logic                 hit;
  logic [CW-1:0]        hit_idx;
  logic [CW-1:0]        next_base;
  logic                 row_end;
  logic [CW-1:0]        tgt_pos;
  logic [RW-1:0]        tgt_row;
  logic [RW-1:0]        rd_row;
  logic                 ram_we;
  logic [RW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  // grown layer count: L + L/4 + 1
  assign nl_c = NLW'(layer_r) + NLW'(layer_r >> 2) + NLW'(1);

  // decision terms
  assign cap_now  = (prod_r > PW'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(prod_r);
  assign cap_full = next_free_r >= cap_now;
  assign grow_ok  = grow_en_r && (nl_r <= NLW'(LMAX)) && (gprod_r <= PW'(MAX_SLOTS)) &&
                    (gprod_r > PW'(next_free_r));
  assign rel_oor  = CW'(slot_r) >= CW'(cap_now);

  // target row modify: set on allocate, clear on release
  assign bit_sel  = WORD_BITS'(1) << WORD_SH'(pos_r);
  assign mod_word = (kind_r == KIND_RELEASE) ? (rd_data & ~bit_sel) : (rd_data | bit_sel);
  assign scan_word = cmd.modify ? mod_word : rd_data;

  // free slots of this row strictly above pos and below capacity
  always_comb begin
    logic [CW-1:0] idx;
    for (int j = 0; j < WORD_BITS; j++) begin
      idx = (CW'(row_r) << WORD_SH) | CW'(j);
      free_vec[j] = !scan_word[j] && (idx > CW'(pos_r)) && (idx < CW'(cap_r));
    end
  end

  assign hit       = |free_vec;
  assign enc       = lowest_set(free_vec);
  assign hit_idx   = (CW'(row_r) << WORD_SH) | CW'(enc);
  assign next_base = (CW'(row_r) + CW'(1)) << WORD_SH;
  assign row_end   = next_base >= CW'(cap_r);

  // row addressing
  assign tgt_pos = (kind_r == KIND_RELEASE) ? CW'(slot_r) : CW'(next_free_r);
  assign tgt_row = RW'(tgt_pos >> WORD_SH);
  assign rd_row  = cmd.decide ? tgt_row : (row_r + RW'(1));

  assign ram_we    = cmd.clr_wr | cmd.modify;
  assign ram_waddr = cmd.clr_wr ? clr_row_r : row_r;
  assign ram_wdata = cmd.clr_wr ? '0 : mod_word;

  // status to the controller
  assign st.fresh     = cfg_we && ((cfg_idx == CFG_INIT_LAYERS) || (cfg_idx == CFG_CELLS));
  assign st.fail      = (kind_r == KIND_RELEASE) ? rel_oor : (cap_full && !grow_ok);
  assign st.scan_more = (cmd.modify || cmd.scan) && (kind_r == KIND_ALLOC) && !hit && !row_end;
  assign st.clr_last  = clr_row_r == RW'(NROWS - 1);

  gsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_row),
    .rdata (rd_data)
  );

  // configuration, layer count, free pointer, clearing row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_layers_r <= LAYER_W'(1);
      cells_r       <= CELLS_W'(16);
      grow_en_r     <= 1'b0;
      layer_r       <= LAYER_W'(1);
      next_free_r   <= '0;
      clr_row_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_INIT_LAYERS: begin
          init_layers_r <= cfg_data;
          layer_r       <= cfg_data;
          next_free_r   <= '0;
          clr_row_r     <= '0;
        end
        CFG_CELLS: begin
          cells_r     <= cfg_data;
          layer_r     <= init_layers_r;
          next_free_r <= '0;
          clr_row_r   <= '0;
        end
        CFG_GROW: begin
          grow_en_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd.clr_wr) begin
        clr_row_r <= clr_row_r + RW'(1);
      end
      if (cmd.decide && (kind_r == KIND_ALLOC) && cap_full && grow_ok) begin
        layer_r <= LAYER_W'(nl_r);
      end
      // release lowers the pointer
      if (cmd.modify && (kind_r == KIND_RELEASE) && (CW'(slot_r) < CW'(next_free_r))) begin
        next_free_r <= SW'(slot_r);
      end
      // allocate moves the pointer forward
      if ((cmd.modify || cmd.scan) && (kind_r == KIND_ALLOC)) begin
        if (hit) begin
          next_free_r <= SW'(hit_idx);
        end else if (row_end) begin
          next_free_r <= cap_r;
        end
      end
    end
  end

  // item working registers and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      slot_r <= in_slot;
    end
    if (cmd.mul) begin
      prod_r  <= PW'(layer_r) * PW'(cells_r);
      nl_r    <= nl_c;
      gprod_r <= PW'(nl_c) * PW'(cells_r);
    end
    if (cmd.decide) begin
      pos_r <= (kind_r == KIND_RELEASE) ? SW'(slot_r) : next_free_r;
      row_r <= tgt_row;
      if (kind_r == KIND_RELEASE) begin
        status_r <= rel_oor ? STATUS_RANGE : STATUS_OK;
        cap_r    <= cap_now;
        grew_r   <= 1'b0;
      end else if (cap_full && grow_ok) begin
        status_r <= STATUS_OK;
        cap_r    <= SW'(gprod_r);
        grew_r   <= 1'b1;
      end else begin
        status_r <= cap_full ? STATUS_FULL : STATUS_OK;
        cap_r    <= cap_now;
        grew_r   <= 1'b0;
      end
    end
    if (st.scan_more) begin
      row_r <= row_r + RW'(1);
    end
    if (cmd.load_out) begin
      out_slot_out <= ((kind_r == KIND_ALLOC) && (status_r == STATUS_OK)) ?
                      SLOT_W'(pos_r) : '0;
      out_status   <= status_r;
      out_grew     <= grew_r;
      out_capacity <= CAP_W'(cap_r);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gsa_ctrl
// Controller: sequences clearing pass, item steps and result handover.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire gsa_pkg::gsa_stat_t st,
  output gsa_pkg::gsa_cmd_t       cmd
);
  import gsa_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_DECIDE,
    S_MODIFY,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // commands per state
  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLEAR:  cmd.clr_wr   = 1'b1;
      S_IDLE:   cmd.capture  = in_valid;
      S_MUL:    cmd.mul      = 1'b1;
      S_DECIDE: cmd.decide   = 1'b1;
      S_MODIFY: cmd.modify   = 1'b1;
      S_SCAN:   cmd.scan     = 1'b1;
      S_DONE:   cmd.load_out = !out_valid_r || out_ready;
      default:  cmd = '0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE:   if (in_valid) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = st.fail ? S_DONE : S_MODIFY;
      S_MODIFY: state_nxt = st.scan_more ? S_SCAN : S_DONE;
      S_SCAN:   state_nxt = st.scan_more ? S_SCAN : S_DONE;
      S_DONE:   if (cmd.load_out) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
    // grid rewrite restarts the clearing pass
    if (st.fresh) begin
      state_nxt = S_CLEAR;
    end
  end

  // result valid: set on load, dropped on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grid_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// grid_slot_allocator
// Lowest-free-slot allocator over a layered grid with optional growth.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        kind, slot
//  out_ch   out  valid/ready        slot_out, status, grew, capacity
//  cfg_*    in   cfg_we, no wait    cfg_idx, cfg_data
//
//  A release passes through the multiply, decide, modify and done steps,
//  a refused allocate or out-of-range release skips the modify step, and an
//  allocate adds a scan step per further 32-slot bitmap row the forward scan
//  reads (one RAM row read per cycle). After reset and after any write to
//  initial_layers or cells_per_layer a clearing pass writes every bitmap row,
//  with in_ch.ready low. A new item is taken while a result waits in the
//  output register; the block holds in its final step until that is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_slot_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [gsa_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [gsa_pkg::CFG_DATA_W-1:0] cfg_data,
  gsa_in_if.sink                              in_ch,
  gsa_out_if.source                           out_ch
);
  import gsa_pkg::*;

  gsa_cmd_t  cmd;
  gsa_stat_t st;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  gsa_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_kind      (in_ch.kind),
    .in_slot      (in_ch.slot),
    .cmd          (cmd),
    .st           (st),
    .out_slot_out (out_ch.slot_out),
    .out_status   (out_ch.status),
    .out_grew     (out_ch.grew),
    .out_capacity (out_ch.capacity)
  );

  // growth only ever comes with a successful allocate
  a_grew_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.grew |-> out_ch.status == STATUS_OK)
    else $error("grew flagged on a failed item");

  // a failed item never hands out a slot
  a_fail_slot : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != STATUS_OK) |-> out_ch.slot_out == '0)
    else $error("slot given on a failed item");

  // row write-back follows the decision step
  a_modify_seq : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.modify |-> $past(cmd.decide))
    else $error("row write-back without decision");

  // scan steps only continue a write-back or an earlier scan
  a_scan_seq : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> ($past(cmd.modify) || $past(cmd.scan)))
    else $error("scan step out of sequence");

endmodule

`default_nettype wire

// ===== tb/sv/grid_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_slot_allocator_tb
// Self-checking bench for the layered-grid slot allocator. A scoreboard
// class keeps its own used-slot map, free pointer and layer count, predicts
// every result from the accepted requests, and checks results in order.
// A directed opening covers full, growth, zero-sized grids, releases of free
// and out-of-range slots and unknown register writes. Random phases follow
// over several grid settings, with bursty stalls and one long output stall.
// ----------------------------------------------------------------------------

module grid_slot_allocator_tb;
  import gsa_pkg::*;

  localparam int unsigned GRID_MAX       = 1024;
  localparam int unsigned LAYER_MAX      = (1 << LAYER_W) - 1;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
    logic                grew;
    logic [CAP_W-1:0]    capacity;
  } grant_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the allocator state and the pending grants
  // --------------------------------------------------------------------------
  class grant_scoreboard;
    int unsigned init_layers;
    int unsigned cells;
    int unsigned grow_en;
    bit          slot_used [GRID_MAX];
    int unsigned next_free;
    int unsigned layer_count;
    grant_t      expected_grants [$];
    int unsigned errors, requests, granted, grown, refused, out_of_range;

    function new();
      init_layers = 1;
      cells       = 16;
      grow_en     = 0;
      fresh_grid();
    endfunction

    function void fresh_grid();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      next_free   = 0;
      layer_count = init_layers;
    endfunction

    // layers times cells, saturated at the grid limit
    function int unsigned grid_capacity(int unsigned layers);
      longint unsigned p;
      p = layers;
      p = p * cells;
      return (p > GRID_MAX) ? GRID_MAX : int'(p);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_INIT_LAYERS: begin
          init_layers = 32'(data);
          fresh_grid();
        end
        CFG_CELLS: begin
          cells = 32'(data);
          fresh_grid();
        end
        CFG_GROW: begin
          grow_en = 32'(data[0]);
        end
        default: ;
      endcase
    endfunction

    // Predict the grant for one accepted request and update the state
    function void note_request(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot);
      grant_t          g;
      int unsigned     cap, nl, pos, i;
      longint unsigned np;
      g   = '0;
      cap = grid_capacity(layer_count);
      requests++;
      if (kind == KIND_ALLOC) begin
        if (next_free >= cap) begin
          nl = layer_count + (layer_count >> 2) + 1;
          np = nl;
          np = np * cells;
          if (grow_en != 0 && nl <= LAYER_MAX && np <= GRID_MAX && np > next_free) begin
            layer_count = nl;
            cap         = int'(np);
            g.grew      = 1'b1;
            grown++;
          end else begin
            g.status = STATUS_FULL;
            refused++;
          end
        end
        if (g.status == STATUS_OK) begin
          pos            = next_free;
          slot_used[pos] = 1'b1;
          next_free      = cap;
          // forward scan for the next free slot
          for (i = pos + 1; i < cap && next_free == cap; i++)
            if (!slot_used[i]) next_free = i;
          g.slot_out = SLOT_W'(pos);
          granted++;
        end
      end else begin
        if (slot >= cap) begin
          g.status = STATUS_RANGE;
          out_of_range++;
        end else begin
          slot_used[slot] = 1'b0;
          if (slot < next_free) next_free = 32'(slot);
        end
      end
      g.capacity = CAP_W'(cap);
      expected_grants = {expected_grants, g};
    endfunction

    function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [SLOT_W-1:0] slot_out, logic [STATUS_W-1:0] status,
                               logic grew, logic [CAP_W-1:0] capacity);
      grant_t e;
      if (expected_grants.size() == 0) begin
        $error("result with no request pending: slot_out %0d status %0d", slot_out, status);
        errors++;
        return;
      end
      e = expected_grants.pop_front();
      compare_field("slot_out", e.slot_out, slot_out);
      compare_field("status", e.status, status);
      compare_field("grew", e.grew, grew);
      compare_field("capacity", e.capacity, capacity);
    endfunction

    // A used slot below capacity, or any slot when none is used
    function logic [SLOT_W-1:0] pick_live_slot();
      int unsigned live [$];
      int unsigned cap;
      cap = grid_capacity(layer_count);
      foreach (slot_used[i])
        if (slot_used[i] && i < cap) live = {live, i};
      if (live.size() == 0) return SLOT_W'($urandom_range(0, GRID_MAX - 1));
      return SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, channels, DUT
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  gsa_in_if  in_if ();
  gsa_out_if out_if ();

  grid_slot_allocator #(.MAX_SLOTS(GRID_MAX)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  grant_scoreboard ledger = new();
  bit              no_idle;
  bit              hold_off_req;
  int unsigned     stall_cycles;
  int unsigned     settings;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: register writes, request transfers, result transfers
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) ledger.write_reg(cfg_idx, cfg_data);
      if (out_if.valid && out_if.ready)
        ledger.check_result(out_if.slot_out, out_if.status, out_if.grew, out_if.capacity);
      if (in_if.valid && in_if.ready) ledger.note_request(in_if.kind, in_if.slot);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: bursts of ready, bursts of stall, one long hold-off
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  // Offer one request and wait for its transfer
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot);
    if (!no_idle && !hold_off_req && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.kind  <= kind;
    in_if.slot  <= slot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Wait until every grant is in and the block takes requests again
  task automatic settle();
    repeat (4) @(posedge clk);
    while (ledger.expected_grants.size() != 0 || !in_if.ready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_if.valid <= 1'b0;
    settle();
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // One grid setting, then a random mix of allocates and releases
  task automatic run_phase(input int unsigned layers, input int unsigned cells,
                           input int unsigned grow, input int unsigned count,
                           input bit pressure, input bit calm);
    int unsigned n, r, cap;
    write_reg(CFG_INIT_LAYERS, CFG_DATA_W'(layers));
    write_reg(CFG_CELLS, CFG_DATA_W'(cells));
    write_reg(CFG_GROW, CFG_DATA_W'(grow));
    settings++;
    no_idle = calm;
    if (pressure) hold_off_req = 1'b1;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        send_item(KIND_ALLOC, SLOT_W'($urandom_range(0, GRID_MAX - 1)));
      end else if (r < 88) begin
        send_item(KIND_RELEASE, ledger.pick_live_slot());
      end else if (r < 94) begin
        // release right at the capacity boundary
        cap = ledger.grid_capacity(ledger.layer_count);
        if (cap < GRID_MAX) send_item(KIND_RELEASE, SLOT_W'(cap));
        else send_item(KIND_RELEASE, SLOT_W'(GRID_MAX - 1));
      end else begin
        send_item(KIND_RELEASE, SLOT_W'($urandom_range(0, GRID_MAX - 1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned k;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CFG_INIT_LAYERS;
    cfg_data     <= '0;
    in_if.valid  <= 1'b0;
    in_if.kind   <= KIND_ALLOC;
    in_if.slot   <= '0;
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    settings     = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fill a four-slot grid, then full
    write_reg(CFG_CELLS, 11'd4);
    for (k = 0; k < 5; k++) send_item(KIND_ALLOC, '1);
    // release a used slot, the same slot again, the boundary and the top index
    send_item(KIND_RELEASE, 10'd2);
    send_item(KIND_RELEASE, 10'd2);
    send_item(KIND_RELEASE, 10'd4);
    send_item(KIND_RELEASE, '1);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_ALLOC, '0);
    // growth from one layer to two
    write_reg(CFG_GROW, 11'd1);
    send_item(KIND_ALLOC, '0);
    // unknown register index leaves everything alone
    write_reg(CFG_UNUSED, '1);
    send_item(KIND_ALLOC, '0);
    // zero cells: growth gives no room
    write_reg(CFG_CELLS, 11'd0);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_RELEASE, 10'd0);
    // zero layers: growth to one layer makes room
    write_reg(CFG_INIT_LAYERS, 11'd0);
    write_reg(CFG_CELLS, 11'd5);
    send_item(KIND_ALLOC, '0);
    // oversized grid saturates
    write_reg(CFG_INIT_LAYERS, 11'd1024);
    write_reg(CFG_CELLS, 11'd1024);
    send_item(KIND_ALLOC, '0);
    send_item(KIND_RELEASE, 10'd1023);
    send_item(KIND_ALLOC, '0);
    write_reg(CFG_GROW, 11'd0);
    settings += 5;

    // Random phases over a spread of grids
    run_phase(1, 16, 1, 150, 1'b0, 1'b0);
    run_phase(3, 5, 0, 100, 1'b1, 1'b0);
    run_phase(0, 7, 1, 120, 1'b0, 1'b0);
    run_phase(2, 1, 1, 100, 1'b0, 1'b0);
    run_phase(1024, 1, 0, 80, 1'b0, 1'b0);
    run_phase(1, 1024, 1, 60, 1'b0, 1'b0);
    run_phase(5, 3, 1, 150, 1'b0, 1'b0);
    run_phase(1, 1023, 0, 60, 1'b0, 1'b0);
    run_phase(4, 16, 1, 250, 1'b0, 1'b1);

    // Drain
    in_if.valid <= 1'b0;
    while (ledger.expected_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (ledger.expected_grants.size() != 0) begin
      $error("%0d grants never arrived", ledger.expected_grants.size());
      ledger.errors++;
    end

    $display("Covered %0d requests over %0d grid settings, growth on and off.",
             ledger.requests, settings);
    $display("Grants %0d, growths %0d, full refusals %0d, out-of-range releases %0d.",
             ledger.granted, ledger.grown, ledger.refused, ledger.out_of_range);
    if (ledger.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gsa_pkg.sv
rtl/gsa_channels.sv
rtl/gsa_ram.sv
rtl/gsa_datapath.sv
rtl/gsa_ctrl.sv
rtl/grid_slot_allocator.sv
tb/sv/grid_slot_allocator_tb.sv
